// ===== hdl/tracker_pattern_unpacker_macros.svh =====
// assertion shorthands shared by the unpacker modules
// every use expects clk and rst_n in scope
`ifndef TRACKER_PATTERN_UNPACKER_MACROS_SVH
`define TRACKER_PATTERN_UNPACKER_MACROS_SVH

// same-cycle implication
`define TPU_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define TPU_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== hdl/tpu_pkg.sv =====
`default_nettype none

package tpu_pkg;

  // channel history depth
  localparam int CHANNELS = 64;
  localparam int CH_AW    = $clog2(CHANNELS);

  // history stores: note, instrument, volume, effect, parameter
  localparam int HIST_N = 5;

  // op queue between parser and cell builder
  localparam int QDEPTH = 4;

  // input word
  typedef struct packed {
    logic       cmd;
    logic [7:0] data_byte;
  } in_word_t;

  // result kinds
  typedef enum logic [1:0] {
    KIND_CELL     = 2'd0,
    KIND_DONE     = 2'd1,
    KIND_BADCH    = 2'd2,
    KIND_MISMATCH = 2'd3
  } res_kind_t;

  // result word
  typedef struct packed {
    res_kind_t  kind;
    logic [7:0] row;
    logic [5:0] channel;
    logic [7:0] note;
    logic [7:0] instrument;
    logic [7:0] volume;
    logic [7:0] effect;
    logic [7:0] effect_param;
  } out_word_t;

  // configuration register indexes
  typedef enum logic [1:0] {
    CFG_ROW_COUNT     = 2'd0,
    CFG_CHANNEL_COUNT = 2'd1,
    CFG_PACKED_LENGTH = 2'd2,
    CFG_NOTE_LIMIT    = 2'd3
  } cfg_idx_t;

  // ops handed from the parser to the cell builder
  typedef enum logic [1:0] {
    OP_CLEAR  = 2'd0,
    OP_START  = 2'd1,
    OP_FIELD  = 2'd2,
    OP_RESULT = 2'd3
  } op_code_t;

  // field selector, also the history store index
  typedef enum logic [2:0] {
    FLD_NOTE  = 3'd0,
    FLD_INS   = 3'd1,
    FLD_VOL   = 3'd2,
    FLD_EFF   = 3'd3,
    FLD_PARAM = 3'd4
  } fld_t;

  typedef struct packed {
    op_code_t   code;
    logic       last;   // cell completes with this op
    res_kind_t  kind;
    logic [7:0] row;
    logic [5:0] ch;
    fld_t       fld;
    logic [7:0] data;   // mask for a start, stream value for a field
  } op_t;

  // note conversion: note off first, then the limit check
  function automatic logic [7:0] conv_note(input logic [7:0] n, input logic [7:0] lim);
    logic [7:0] res;
    if (n == 8'hFF) begin
      res = 8'hFE;
    end else if (n >= lim) begin
      res = 8'hFF;
    end else begin
      res = n;
    end
    return res;
  endfunction

  // volume clamp and offset
  function automatic logic [7:0] conv_vol(input logic [7:0] v);
    logic [7:0] res;
    if (v > 8'd64) begin
      res = 8'd80;
    end else begin
      res = v + 8'd16;
    end
    return res;
  endfunction

endpackage

`default_nettype wire

// ===== hdl/tpu_front.sv =====
`default_nettype none
`include "tracker_pattern_unpacker_macros.svh"

module tpu_front (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  tpu_pkg::in_word_t  in_word,
  input  logic [8:0]         row_count,
  input  logic [6:0]         channel_count,
  input  logic [15:0]        packed_length,
  output logic               push,
  output tpu_pkg::op_t       push_op,
  input  logic               q_full
);
  import tpu_pkg::*;

  typedef enum logic [8:0] {
    PH_CHAN  = 9'b000000001,
    PH_MASK  = 9'b000000010,
    PH_LOOK  = 9'b000000100,
    PH_NOTE  = 9'b000001000,
    PH_INS   = 9'b000010000,
    PH_VOL   = 9'b000100000,
    PH_EFF   = 9'b001000000,
    PH_PARAM = 9'b010000000,
    PH_HALT  = 9'b100000000
  } phase_t;

  // first field at or after 'from' that reads the stream
  function automatic phase_t phase_from(input logic [3:0] rd, input logic [2:0] from);
    phase_t ph;
    ph = PH_CHAN;
    if (rd[3] && from <= 3'd3) ph = PH_EFF;
    if (rd[2] && from <= 3'd2) ph = PH_VOL;
    if (rd[1] && from <= 3'd1) ph = PH_INS;
    if (rd[0] && from == 3'd0) ph = PH_NOTE;
    return ph;
  endfunction

  phase_t       phase_r, phase_nxt;
  logic [8:0]   row_cnt_r, row_nxt;
  logic [15:0]  byte_cnt_r, byte_nxt;
  logic [5:0]   cur_ch_r, ch_nxt;
  logic [7:0]   cur_mask_r, mask_nxt;

  logic [7:0]          mask_mem [CHANNELS];
  logic [CHANNELS-1:0] mask_vld_r;
  logic [7:0]          mask_rd_r;
  logic                mask_we, mask_rd_en, hist_clr;

  logic       acc;
  logic [7:0] din, din_m1;
  logic [5:0] chx;

  assign din      = in_word.data_byte;
  assign din_m1   = din - 8'd1;
  assign chx      = din_m1[5:0];
  assign in_stall = (phase_r == PH_LOOK) || q_full;
  assign acc      = in_valid && !in_stall;

  // parser step
  always_comb begin
    phase_nxt  = phase_r;
    row_nxt    = row_cnt_r;
    byte_nxt   = byte_cnt_r;
    ch_nxt     = cur_ch_r;
    mask_nxt   = cur_mask_r;
    mask_we    = 1'b0;
    mask_rd_en = 1'b0;
    hist_clr   = 1'b0;
    push       = 1'b0;
    push_op    = '0;
    push_op.row  = row_cnt_r[7:0];
    push_op.ch   = cur_ch_r;
    push_op.data = din;
    if (phase_r == PH_LOOK) begin
      // stored mask is back from memory
      if (!q_full) begin
        mask_nxt     = mask_rd_r;
        phase_nxt    = phase_from(mask_rd_r[3:0], 3'd0);
        push         = 1'b1;
        push_op.code = OP_START;
        push_op.data = mask_rd_r;
        push_op.last = (phase_nxt == PH_CHAN);
      end
    end else if (acc) begin
      if (in_word.cmd) begin
        // new pattern
        phase_nxt    = PH_CHAN;
        row_nxt      = '0;
        byte_nxt     = '0;
        ch_nxt       = '0;
        mask_nxt     = '0;
        hist_clr     = 1'b1;
        push         = 1'b1;
        push_op.code = OP_CLEAR;
      end else if (phase_r != PH_HALT) begin
        byte_nxt = byte_cnt_r + 16'd1;
        case (phase_r)
          PH_CHAN: begin
            if (din == 8'd0) begin
              // row end, maybe pattern end
              row_nxt = row_cnt_r + 9'd1;
              if (row_nxt >= row_count) begin
                phase_nxt    = PH_HALT;
                push         = 1'b1;
                push_op.code = OP_RESULT;
                push_op.kind = (byte_nxt == packed_length) ? KIND_DONE : KIND_MISMATCH;
                push_op.row  = row_nxt[7:0];
                push_op.ch   = '0;
              end
            end else if ({1'b0, chx} >= channel_count || {1'b0, chx} >= 7'(CHANNELS)) begin
              phase_nxt    = PH_HALT;
              push         = 1'b1;
              push_op.code = OP_RESULT;
              push_op.kind = KIND_BADCH;
              push_op.ch   = chx;
            end else begin
              ch_nxt     = chx;
              mask_rd_en = 1'b1;
              phase_nxt  = din[7] ? PH_MASK : PH_LOOK;
            end
          end
          PH_MASK: begin
            mask_we      = 1'b1;
            mask_nxt     = din;
            phase_nxt    = phase_from(din[3:0], 3'd0);
            push         = 1'b1;
            push_op.code = OP_START;
            push_op.last = (phase_nxt == PH_CHAN);
          end
          PH_NOTE: begin
            phase_nxt    = phase_from(cur_mask_r[3:0], 3'd1);
            push         = 1'b1;
            push_op.code = OP_FIELD;
            push_op.fld  = FLD_NOTE;
            push_op.last = (phase_nxt == PH_CHAN);
          end
          PH_INS: begin
            phase_nxt    = phase_from(cur_mask_r[3:0], 3'd2);
            push         = 1'b1;
            push_op.code = OP_FIELD;
            push_op.fld  = FLD_INS;
            push_op.last = (phase_nxt == PH_CHAN);
          end
          PH_VOL: begin
            phase_nxt    = phase_from(cur_mask_r[3:0], 3'd3);
            push         = 1'b1;
            push_op.code = OP_FIELD;
            push_op.fld  = FLD_VOL;
            push_op.last = (phase_nxt == PH_CHAN);
          end
          PH_EFF: begin
            phase_nxt    = PH_PARAM;
            push         = 1'b1;
            push_op.code = OP_FIELD;
            push_op.fld  = FLD_EFF;
          end
          PH_PARAM: begin
            phase_nxt    = PH_CHAN;
            push         = 1'b1;
            push_op.code = OP_FIELD;
            push_op.fld  = FLD_PARAM;
            push_op.last = 1'b1;
          end
          default: begin
            phase_nxt = phase_r;
          end
        endcase
      end
    end
  end

  // parser state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r    <= PH_CHAN;
      row_cnt_r  <= '0;
      byte_cnt_r <= '0;
      cur_ch_r   <= '0;
      cur_mask_r <= '0;
    end else begin
      phase_r    <= phase_nxt;
      row_cnt_r  <= row_nxt;
      byte_cnt_r <= byte_nxt;
      cur_ch_r   <= ch_nxt;
      cur_mask_r <= mask_nxt;
    end
  end

  // mask memory, addressed by the incoming channel byte on read
  always_ff @(posedge clk) begin
    if (mask_we) begin
      mask_mem[cur_ch_r[CH_AW-1:0]] <= din;
    end
    if (mask_rd_en) begin
      mask_rd_r <= mask_vld_r[chx[CH_AW-1:0]] ? mask_mem[chx[CH_AW-1:0]] : 8'd0;
    end
  end

  // mask valid bits, cleared at once
  always_ff @(posedge clk) begin
    if (!rst_n || hist_clr) begin
      mask_vld_r <= '0;
    end else if (mask_we) begin
      mask_vld_r[cur_ch_r[CH_AW-1:0]] <= 1'b1;
    end
  end

  `TPU_ASSERT_IMP(a_halt_quiet, phase_r == PH_HALT && !(acc && in_word.cmd), !push, "op pushed while halted")
  `TPU_ASSERT_NXT(a_start_clears, acc && in_word.cmd, phase_r == PH_CHAN && byte_cnt_r == 16'd0, "pattern start did not reset parser")

endmodule

`default_nettype wire

// ===== hdl/tpu_queue.sv =====
`default_nettype none
`include "tracker_pattern_unpacker_macros.svh"

module tpu_queue (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          push,
  input  tpu_pkg::op_t  push_op,
  output logic          full,
  input  logic          pop,
  output logic          q_valid,
  output tpu_pkg::op_t  q_op
);
  import tpu_pkg::*;

  localparam int PW = $clog2(QDEPTH);
  localparam int CW = $clog2(QDEPTH + 1);

  op_t           slot_r [QDEPTH];
  logic [PW-1:0] wr_ptr_r, rd_ptr_r;
  logic [CW-1:0] cnt_r;
  logic          do_push, do_pop;

  assign full    = (cnt_r == CW'(QDEPTH));
  assign q_valid = (cnt_r != '0);
  assign q_op    = slot_r[rd_ptr_r];
  assign do_push = push && !full;
  assign do_pop  = pop && q_valid;

  // storage
  always_ff @(posedge clk) begin
    if (do_push) begin
      slot_r[wr_ptr_r] <= push_op;
    end
  end

  // pointers and fill level
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (do_push) wr_ptr_r <= (wr_ptr_r == PW'(QDEPTH - 1)) ? '0 : wr_ptr_r + PW'(1);
      if (do_pop)  rd_ptr_r <= (rd_ptr_r == PW'(QDEPTH - 1)) ? '0 : rd_ptr_r + PW'(1);
      if (do_push && !do_pop) begin
        cnt_r <= cnt_r + CW'(1);
      end else if (do_pop && !do_push) begin
        cnt_r <= cnt_r - CW'(1);
      end
    end
  end

  `TPU_ASSERT_IMP(a_no_overflow, push, !full, "push into full queue")

endmodule

`default_nettype wire

// ===== hdl/tpu_back.sv =====
`default_nettype none
`include "tracker_pattern_unpacker_macros.svh"

module tpu_back (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                q_valid,
  input  tpu_pkg::op_t        q_op,
  output logic                pop,
  input  logic [7:0]          note_limit,
  output logic                out_valid,
  input  logic                out_stall,
  output tpu_pkg::out_word_t  out_word
);
  import tpu_pkg::*;

  typedef struct packed {
    logic [7:0] note;
    logic [7:0] ins;
    logic [7:0] vol;
    logic [7:0] eff;
    logic [7:0] param;
  } cell_t;

  logic        ex_valid_r;
  op_t         ex_op_r;
  cell_t       cell_r, cell_nxt;
  logic [7:0]  hist_rd [HIST_N];
  logic        has_out, out_free, fire, hist_clr;
  logic        out_valid_r;
  out_word_t   out_word_r, res_word;

  assign has_out  = (ex_op_r.code == OP_RESULT) ||
                    (ex_op_r.last && (ex_op_r.code == OP_START || ex_op_r.code == OP_FIELD));
  assign out_free = !out_valid_r || !out_stall;
  assign fire     = ex_valid_r && (!has_out || out_free);
  assign pop      = q_valid && (!ex_valid_r || fire);
  assign hist_clr = fire && (ex_op_r.code == OP_CLEAR);

  // per-channel history: one store per field, read when an op leaves the queue
  for (genvar g = 0; g < HIST_N; g++) begin : hist_g
    logic [7:0]          mem [CHANNELS];
    logic [CHANNELS-1:0] vld_r;
    logic [7:0]          rd_r;
    logic                we;
    logic                hit;

    assign we  = fire && (ex_op_r.code == OP_FIELD) && (ex_op_r.fld == fld_t'(g));
    assign hit = we && (ex_op_r.ch[CH_AW-1:0] == q_op.ch[CH_AW-1:0]);

    always_ff @(posedge clk) begin
      if (we) begin
        mem[ex_op_r.ch[CH_AW-1:0]] <= ex_op_r.data;
      end
      if (pop) begin
        // forward a write to the same channel, a clear wins over stored data
        if (hist_clr) begin
          rd_r <= 8'd0;
        end else if (hit) begin
          rd_r <= ex_op_r.data;
        end else begin
          rd_r <= vld_r[q_op.ch[CH_AW-1:0]] ? mem[q_op.ch[CH_AW-1:0]] : 8'd0;
        end
      end
    end

    always_ff @(posedge clk) begin
      if (!rst_n || hist_clr) begin
        vld_r <= '0;
      end else if (we) begin
        vld_r[ex_op_r.ch[CH_AW-1:0]] <= 1'b1;
      end
    end

    assign hist_rd[g] = rd_r;
  end

  // cell assembly
  always_comb begin
    cell_nxt = cell_r;
    case (ex_op_r.code)
      OP_START: begin
        cell_nxt.note  = ex_op_r.data[4] ? conv_note(hist_rd[FLD_NOTE], note_limit) : 8'hFF;
        cell_nxt.ins   = ex_op_r.data[5] ? hist_rd[FLD_INS] : 8'd0;
        cell_nxt.vol   = ex_op_r.data[6] ? conv_vol(hist_rd[FLD_VOL]) : 8'hFF;
        cell_nxt.eff   = ex_op_r.data[7] ? hist_rd[FLD_EFF] : 8'd0;
        cell_nxt.param = ex_op_r.data[7] ? hist_rd[FLD_PARAM] : 8'd0;
      end
      OP_FIELD: begin
        case (ex_op_r.fld)
          FLD_NOTE:  cell_nxt.note  = conv_note(ex_op_r.data, note_limit);
          FLD_INS:   cell_nxt.ins   = ex_op_r.data;
          FLD_VOL:   cell_nxt.vol   = conv_vol(ex_op_r.data);
          FLD_EFF:   cell_nxt.eff   = ex_op_r.data;
          FLD_PARAM: cell_nxt.param = ex_op_r.data;
          default:   cell_nxt = cell_r;
        endcase
      end
      default: begin
        cell_nxt = cell_r;
      end
    endcase
  end

  // result word
  always_comb begin
    res_word         = '0;
    res_word.row     = ex_op_r.row;
    res_word.channel = ex_op_r.ch;
    if (ex_op_r.code == OP_RESULT) begin
      res_word.kind = ex_op_r.kind;
    end else begin
      res_word.kind         = KIND_CELL;
      res_word.note         = cell_nxt.note;
      res_word.instrument   = cell_nxt.ins;
      res_word.volume       = cell_nxt.vol;
      res_word.effect       = cell_nxt.eff;
      res_word.effect_param = cell_nxt.param;
    end
  end

  // execute stage control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ex_valid_r <= 1'b0;
    end else if (pop) begin
      ex_valid_r <= 1'b1;
    end else if (fire) begin
      ex_valid_r <= 1'b0;
    end
  end

  // execute stage payload
  always_ff @(posedge clk) begin
    if (pop) begin
      ex_op_r <= q_op;
    end
    if (fire) begin
      cell_r <= cell_nxt;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (fire && has_out) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (fire && has_out) begin
      out_word_r <= res_word;
    end
  end

  assign out_valid = out_valid_r;
  assign out_word  = out_word_r;

  `TPU_ASSERT_NXT(a_result_out, fire && ex_op_r.code == OP_RESULT, out_valid_r && out_word_r.kind != KIND_CELL, "end or error word not shown")
  `TPU_ASSERT_NXT(a_ex_hold, ex_valid_r && !fire, ex_valid_r && $stable(ex_op_r), "blocked op lost")

endmodule

`default_nettype wire

// ===== hdl/tracker_pattern_unpacker.sv =====
// channel | direction | handshake         | word
// in_     | input     | in_valid/in_stall   | in_word: cmd, data_byte
// out_    | output    | out_valid/out_stall | out_word: kind, row, channel, cell fields
// cfg_    | input     | cfg_valid/cfg_ready | cfg_index, cfg_data (always ready)
//
// one packed byte per cycle while the op queue has room; a channel byte that uses
// the stored mask holds off the next byte while the mask memory read returns
// a word passes the op queue, the execute stage and the output register on its way to
// out_valid; a cell that ends on a stored mask with no fields to read also waits for that read
// synchronous active-low reset; history stores are cleared at once by valid bits
// out_stall backs up the four-entry op queue, which then raises in_stall
`default_nettype none

module tracker_pattern_unpacker (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  tpu_pkg::in_word_t   in_word,
  output logic                out_valid,
  input  logic                out_stall,
  output tpu_pkg::out_word_t  out_word,
  input  logic                cfg_valid,
  output logic                cfg_ready,
  input  logic [1:0]          cfg_index,
  input  logic [15:0]         cfg_data
);
  import tpu_pkg::*;

  logic [8:0]  row_count_r;
  logic [6:0]  channel_count_r;
  logic [15:0] packed_length_r;
  logic [7:0]  note_limit_r;

  logic        push, q_full, pop, q_valid;
  op_t         push_op, q_op;

  assign cfg_ready = 1'b1;

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      row_count_r     <= 9'd64;
      channel_count_r <= 7'd64;
      packed_length_r <= 16'd0;
      note_limit_r    <= 8'd120;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_idx_t'(cfg_index))
        CFG_ROW_COUNT:     row_count_r     <= cfg_data[8:0];
        CFG_CHANNEL_COUNT: channel_count_r <= cfg_data[6:0];
        CFG_PACKED_LENGTH: packed_length_r <= cfg_data;
        CFG_NOTE_LIMIT:    note_limit_r    <= cfg_data[7:0];
        default:           row_count_r     <= row_count_r;
      endcase
    end
  end

  // byte parser
  tpu_front u_front (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .in_word       (in_word),
    .row_count     (row_count_r),
    .channel_count (channel_count_r),
    .packed_length (packed_length_r),
    .push          (push),
    .push_op       (push_op),
    .q_full        (q_full)
  );

  // op queue
  tpu_queue u_queue (
    .clk     (clk),
    .rst_n   (rst_n),
    .push    (push),
    .push_op (push_op),
    .full    (q_full),
    .pop     (pop),
    .q_valid (q_valid),
    .q_op    (q_op)
  );

  // cell builder and output register
  tpu_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .q_valid    (q_valid),
    .q_op       (q_op),
    .pop        (pop),
    .note_limit (note_limit_r),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .out_word   (out_word)
  );

endmodule

`default_nettype wire

// ===== test/tracker_pattern_unpacker_check.sv =====
`timescale 1ns / 100ps

module tracker_pattern_unpacker_check (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  input  logic               in_stall,
  input  tpu_pkg::in_word_t  in_word,
  input  logic               out_valid,
  input  logic               out_stall,
  input  tpu_pkg::out_word_t out_word,
  input  logic               cfg_valid,
  input  logic               cfg_ready,
  input  logic [1:0]         cfg_index,
  input  logic [15:0]        cfg_data,
  output int                 fail_count,
  output int                 words_pending,
  output int                 cells_seen,
  output int                 done_seen,
  output int                 mismatch_seen,
  output int                 badch_seen
);

  // where the parser stands in the packed stream
  typedef enum logic [2:0] {
    PH_CHAN,
    PH_MASK,
    PH_NOTE,
    PH_INS,
    PH_VOL,
    PH_EFF,
    PH_PARAM,
    PH_HALT
  } parse_phase_t;

  // register copies
  logic [8:0]  row_count;
  logic [6:0]  channel_count;
  logic [15:0] packed_length;
  logic [7:0]  note_limit;

  // per-channel history, raw stream values
  logic [7:0] mask_hist  [64];
  logic [7:0] note_hist  [64];
  logic [7:0] ins_hist   [64];
  logic [7:0] vol_hist   [64];
  logic [7:0] eff_hist   [64];
  logic [7:0] param_hist [64];

  // parser state and the cell being built
  logic [8:0]   row_no;
  logic [15:0]  byte_no;
  parse_phase_t phase;
  logic [5:0]   cur_ch;
  logic [7:0]   cur_mask;
  logic [7:0]   cur_note, cur_ins, cur_vol, cur_eff, cur_param;

  tpu_pkg::out_word_t expected_words[$];
  int n_fail, n_pending, n_cells, n_done, n_mismatch, n_badch;

  assign fail_count    = n_fail;
  assign words_pending = n_pending;
  assign cells_seen    = n_cells;
  assign done_seen     = n_done;
  assign mismatch_seen = n_mismatch;
  assign badch_seen    = n_badch;

  // note off mapping first, then the limit
  function automatic logic [7:0] limit_note(input logic [7:0] n);
    if (n == 8'hFF) begin
      return 8'hFE;
    end
    if (n >= note_limit) begin
      return 8'hFF;
    end
    return n;
  endfunction

  function automatic logic [7:0] offset_volume(input logic [7:0] v);
    return ((v > 8'd64) ? 8'd64 : v) + 8'd16;
  endfunction

  task automatic blank_fields();
    cur_note  = 8'hFF;
    cur_ins   = 8'h00;
    cur_vol   = 8'hFF;
    cur_eff   = 8'h00;
    cur_param = 8'h00;
  endtask

  // pattern start: history, counters and parser all back to zero
  task automatic clear_pattern();
    for (int i = 0; i < 64; i++) begin
      mask_hist[i]  = '0;
      note_hist[i]  = '0;
      ins_hist[i]   = '0;
      vol_hist[i]   = '0;
      eff_hist[i]   = '0;
      param_hist[i] = '0;
    end
    row_no   = '0;
    byte_no  = '0;
    phase    = PH_CHAN;
    cur_ch   = '0;
    cur_mask = '0;
    blank_fields();
  endtask

  task automatic expect_word(input tpu_pkg::res_kind_t kind, input logic [5:0] ch,
                             input bit with_fields);
    tpu_pkg::out_word_t w;
    w         = '0;
    w.kind    = kind;
    w.row     = row_no[7:0];
    w.channel = ch;
    if (with_fields) begin
      w.note         = cur_note;
      w.instrument   = cur_ins;
      w.volume       = cur_vol;
      w.effect       = cur_eff;
      w.effect_param = cur_param;
    end
    expected_words.push_back(w);
  endtask

  // walk the mask from one field on: stop at a field read from the stream,
  // otherwise pull reused values and complete the cell
  task automatic finish_fields(input int first);
    bit waiting;
    int f;
    waiting = 1'b0;
    f = first;
    while (!waiting && f < 4) begin
      if (cur_mask[f]) begin
        waiting = 1'b1;
        phase = parse_phase_t'(PH_NOTE + f);
      end else begin
        if (cur_mask[f + 4]) begin
          case (f)
            0: cur_note = limit_note(note_hist[cur_ch]);
            1: cur_ins = ins_hist[cur_ch];
            2: cur_vol = offset_volume(vol_hist[cur_ch]);
            default: begin
              cur_eff   = eff_hist[cur_ch];
              cur_param = param_hist[cur_ch];
            end
          endcase
        end
        f++;
      end
    end
    if (!waiting) begin
      expect_word(tpu_pkg::KIND_CELL, cur_ch, 1'b1);
      phase = PH_CHAN;
    end
  endtask

  // one accepted input word
  task automatic unpack_word(input tpu_pkg::in_word_t w);
    logic [7:0] b;
    logic [5:0] ch;
    b  = w.data_byte;
    ch = 6'(b - 8'd1);
    if (w.cmd) begin
      clear_pattern();
    end else if (phase != PH_HALT) begin
      byte_no++;
      case (phase)
        PH_CHAN: begin
          if (b == 8'h00) begin
            row_no++;
            if (row_no >= row_count) begin
              expect_word((byte_no == packed_length) ? tpu_pkg::KIND_DONE
                                                     : tpu_pkg::KIND_MISMATCH,
                          6'd0, 1'b0);
              phase = PH_HALT;
            end
          end else if ({1'b0, ch} >= channel_count) begin
            expect_word(tpu_pkg::KIND_BADCH, ch, 1'b0);
            phase = PH_HALT;
          end else begin
            cur_ch = ch;
            blank_fields();
            if (b[7]) begin
              phase = PH_MASK;
            end else begin
              cur_mask = mask_hist[ch];
              finish_fields(0);
            end
          end
        end
        PH_MASK: begin
          mask_hist[cur_ch] = b;
          cur_mask = b;
          finish_fields(0);
        end
        PH_NOTE: begin
          note_hist[cur_ch] = b;
          cur_note = limit_note(b);
          finish_fields(1);
        end
        PH_INS: begin
          ins_hist[cur_ch] = b;
          cur_ins = b;
          finish_fields(2);
        end
        PH_VOL: begin
          vol_hist[cur_ch] = b;
          cur_vol = offset_volume(b);
          finish_fields(3);
        end
        PH_EFF: begin
          eff_hist[cur_ch] = b;
          cur_eff = b;
          phase = PH_PARAM;
        end
        PH_PARAM: begin
          param_hist[cur_ch] = b;
          cur_param = b;
          finish_fields(4);
        end
        default: ;
      endcase
    end
  endtask

  function automatic void same_field(input string name, input logic [7:0] want,
                                     input logic [7:0] got);
    if (want !== got) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      n_fail++;
    end
  endfunction

  task automatic check_word(input tpu_pkg::out_word_t got);
    tpu_pkg::out_word_t want;
    if (expected_words.size() == 0) begin
      $error("result word with none expected: kind %0d row %0d channel %0d",
             got.kind, got.row, got.channel);
      n_fail++;
    end else begin
      want = expected_words.pop_front();
      same_field("kind", {6'b0, want.kind}, {6'b0, got.kind});
      same_field("row", want.row, got.row);
      same_field("channel", {2'b0, want.channel}, {2'b0, got.channel});
      same_field("note", want.note, got.note);
      same_field("instrument", want.instrument, got.instrument);
      same_field("volume", want.volume, got.volume);
      same_field("effect", want.effect, got.effect);
      same_field("effect_param", want.effect_param, got.effect_param);
    end
    case (got.kind)
      tpu_pkg::KIND_CELL:     n_cells++;
      tpu_pkg::KIND_DONE:     n_done++;
      tpu_pkg::KIND_MISMATCH: n_mismatch++;
      default:                n_badch++;
    endcase
  endtask

  initial begin
    n_fail     = 0;
    n_pending  = 0;
    n_cells    = 0;
    n_done     = 0;
    n_mismatch = 0;
    n_badch    = 0;
  end

  // watch all three channels at the rising edge
  always @(posedge clk) begin
    if (!rst_n) begin
      row_count     = 9'd64;
      channel_count = 7'd64;
      packed_length = 16'd0;
      note_limit    = 8'd120;
      clear_pattern();
      expected_words.delete();
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (tpu_pkg::cfg_idx_t'(cfg_index))
          tpu_pkg::CFG_ROW_COUNT:     row_count = cfg_data[8:0];
          tpu_pkg::CFG_CHANNEL_COUNT: channel_count = cfg_data[6:0];
          tpu_pkg::CFG_PACKED_LENGTH: packed_length = cfg_data;
          default:                    note_limit = cfg_data[7:0];
        endcase
      end
      if (in_valid && !in_stall) begin
        unpack_word(in_word);
      end
      if (out_valid && !out_stall) begin
        check_word(out_word);
      end
    end
    n_pending = expected_words.size();
  end

endmodule

// ===== test/tracker_pattern_unpacker_test.sv =====
`timescale 1ns / 100ps

module tracker_pattern_unpacker_test;
  import tpu_pkg::*;

  localparam int LIMIT            = 1_000_000;
  localparam int DRAIN            = 16;
  localparam int WORDS_PER_PHASE  = 670;

  logic       clk;
  logic       rst_n;
  logic       in_valid;
  logic       in_stall;
  in_word_t   in_word;
  logic       out_valid;
  logic       out_stall;
  out_word_t  out_word;
  logic       cfg_valid;
  logic       cfg_ready;
  logic [1:0] cfg_index;
  logic [15:0] cfg_data;

  int fail_count, words_pending, cells_seen, done_seen, mismatch_seen, badch_seen;
  int send_idle_pct, recv_idle_pct, cycles, words_sent, patterns_run, junk_words;

  // words of the pattern about to be sent, and the masks it leaves per channel
  in_word_t   stream[$];
  logic [7:0] gen_mask[64];

  tracker_pattern_unpacker dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_word   (in_word),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_word  (out_word),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  tracker_pattern_unpacker_check u_check (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .in_word       (in_word),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .out_word      (out_word),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .fail_count    (fail_count),
    .words_pending (words_pending),
    .cells_seen    (cells_seen),
    .done_seen     (done_seen),
    .mismatch_seen (mismatch_seen),
    .badch_seen    (badch_seen)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // run limit
  initial begin
    cycles = 0;
    while (cycles < LIMIT) begin
      @(posedge clk);
      cycles++;
    end
    $display("Test completed with failures");
    $finish;
  end

  // receiver stalls at random
  always @(negedge clk) begin
    out_stall <= ($urandom_range(0, 99) < recv_idle_pct);
  end

  task automatic send_word(input in_word_t w);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_word  <= w;
    do begin
      @(posedge clk);
    end while (in_stall);
    @(negedge clk);
  endtask

  // wait until every expected word is back and the block has gone quiet
  task automatic settle();
    in_valid <= 1'b0;
    while (words_pending != 0) begin
      @(negedge clk);
    end
    repeat (DRAIN) @(negedge clk);
  endtask

  task automatic write_reg(input cfg_idx_t idx, input logic [15:0] value);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    do begin
      @(posedge clk);
    end while (!cfg_ready);
    @(negedge clk);
  endtask

  task automatic write_settings(input int rows, input int chans, input int len,
                                input int lim);
    write_reg(CFG_ROW_COUNT, 16'(rows));
    write_reg(CFG_CHANNEL_COUNT, 16'(chans));
    write_reg(CFG_PACKED_LENGTH, 16'(len));
    write_reg(CFG_NOTE_LIMIT, 16'(lim));
    cfg_valid <= 1'b0;
  endtask

  task automatic play_stream();
    foreach (stream[i]) begin
      send_word(stream[i]);
    end
    words_sent += stream.size() - junk_words;
    patterns_run++;
  endtask

  task automatic put_byte(input logic [7:0] b);
    stream.push_back({1'b0, b});
  endtask

  task automatic start_stream();
    stream.delete();
    junk_words = 0;
    foreach (gen_mask[i]) begin
      gen_mask[i] = '0;
    end
    stream.push_back({1'b1, 8'($urandom_range(0, 255))});
  endtask

  // field values leaning on the edges of the conversions
  function automatic logic [7:0] pick_value(input logic [7:0] lim);
    case ($urandom_range(0, 6))
      0: return 8'h00;
      1: return 8'hFF;
      2: return lim;
      3: return lim - 8'd1;
      4: return 8'($urandom_range(60, 68));
      default: return 8'($urandom_range(0, 255));
    endcase
  endfunction

  // channel byte, with or without the upper alias of the channel number
  task automatic channel_byte(input int ch, input bit fresh);
    logic [7:0] v;
    v = 8'(ch + 64 * $urandom_range(0, 1) + 1);
    if (fresh) begin
      v = v | 8'h80;
    end else if (v == 8'h80) begin
      v = 8'h40;
    end
    put_byte(v);
  endtask

  task automatic append_cell(input int ch, input logic [7:0] lim);
    bit fresh;
    logic [7:0] mask;
    fresh = ($urandom_range(0, 3) != 0);
    channel_byte(ch, fresh);
    if (fresh) begin
      case ($urandom_range(0, 5))
        0: mask = 8'h0F;
        1: mask = 8'hF0;
        2: mask = 8'hFF;
        3: mask = 8'h00;
        default: mask = 8'($urandom_range(0, 255));
      endcase
      put_byte(mask);
      gen_mask[ch] = mask;
    end else begin
      mask = gen_mask[ch];
    end
    if (mask[0]) put_byte(pick_value(lim));
    if (mask[1]) put_byte(pick_value(lim));
    if (mask[2]) put_byte(pick_value(lim));
    if (mask[3]) begin
      put_byte(8'($urandom_range(0, 255)));
      put_byte(pick_value(lim));
    end
  endtask

  // well-formed pattern, optionally cut short by a channel out of range
  task automatic build_pattern(input int rows, input int chans, input logic [7:0] lim,
                               input int min_len, input bit bad, output int len);
    int bad_row;
    int r;
    bit halted;
    start_stream();
    bad_row = (bad && chans < 64) ? $urandom_range(0, rows - 1) : -1;
    halted = 1'b0;
    for (r = 0; r < rows && !halted; r++) begin
      repeat ((rows > 16) ? $urandom_range(0, 1) : $urandom_range(0, 4)) begin
        append_cell($urandom_range(0, chans - 1), lim);
      end
      if (r == rows - 1) begin
        while (stream.size() - 1 < min_len) begin
          append_cell($urandom_range(0, chans - 1), lim);
        end
      end
      if (r == bad_row) begin
        channel_byte($urandom_range(chans, 63), $urandom_range(0, 1));
        junk_words = $urandom_range(0, 4);
        repeat (junk_words) put_byte(8'($urandom_range(0, 255)));
        halted = 1'b1;
      end else begin
        put_byte(8'h00);
      end
    end
    len = stream.size() - 1;
  endtask

  task automatic random_pattern();
    int rows, chans, lim, len, style, cut;
    case ($urandom_range(0, 9))
      0: rows = 1;
      1: rows = 256;
      default: rows = $urandom_range(1, 6);
    endcase
    case ($urandom_range(0, 3))
      0: chans = 2;
      1: chans = 64;
      default: chans = $urandom_range(2, 64);
    endcase
    case ($urandom_range(0, 3))
      0: lim = 1;
      1: lim = 254;
      default: lim = $urandom_range(1, 254);
    endcase
    style = $urandom_range(0, 9);
    if (style == 0) begin
      // raw noise with stray pattern starts
      start_stream();
      repeat ($urandom_range(5, 30)) begin
        stream.push_back({($urandom_range(0, 15) == 0), 8'($urandom_range(0, 255))});
      end
      len = $urandom_range(0, 65535);
    end else begin
      build_pattern(rows, chans, 8'(lim), 0, style == 1, len);
      if (style == 2) begin
        // broken off mid-pattern
        cut = $urandom_range(1, stream.size() - 1);
        while (stream.size() > cut) begin
          void'(stream.pop_back());
        end
        junk_words = 0;
      end
      case ($urandom_range(0, 5))
        0: len = 0;
        1: len = 65535;
        2: len = len + $urandom_range(1, 3);
        default: ;
      endcase
    end
    settle();
    write_settings(rows, chans, len, lim);
    play_stream();
  endtask

  // hand-built patterns over the conversion edges, reuse and a bad channel
  task automatic directed_patterns();
    logic [7:0] seq[$];
    start_stream();
    seq = '{8'h81, 8'h0F, 8'hFF, 8'h00, 8'h41, 8'hFF, 8'h00,
            8'h82, 8'hF0,
            8'h01, 8'h00, 8'hFF, 8'h00, 8'h00, 8'hFF,
            8'hC0, 8'h00,
            8'h00,
            8'h81, 8'hF5, 8'h82, 8'h40,
            8'h00};
    foreach (seq[i]) put_byte(seq[i]);
    settle();
    write_settings(2, 64, seq.size(), 120);
    play_stream();

    start_stream();
    seq = '{8'h82, 8'h01, 8'hFF, 8'h02, 8'h00, 8'h02, 8'h01, 8'h03, 8'h00};
    foreach (seq[i]) put_byte(seq[i]);
    junk_words = 1;
    settle();
    write_settings(1, 2, 65535, 1);
    play_stream();
  endtask

  initial begin
    int mark;
    rst_n         = 1'b0;
    in_valid      = 1'b0;
    in_word       = '0;
    out_stall     = 1'b0;
    cfg_valid     = 1'b0;
    cfg_index     = '0;
    cfg_data      = '0;
    send_idle_pct = 0;
    recv_idle_pct = 0;
    words_sent    = 0;
    patterns_run  = 0;
    junk_words    = 0;
    repeat (7) @(negedge clk);
    rst_n <= 1'b1;

    directed_patterns();

    // three idling phases: sender light, receiver light, none
    for (int p = 0; p < 3; p++) begin
      send_idle_pct = (p == 0) ? 31 : (p == 1) ? 70 : 0;
      recv_idle_pct = (p == 0) ? 70 : (p == 1) ? 31 : 0;
      mark = words_sent;
      while (words_sent - mark < WORDS_PER_PHASE) begin
        random_pattern();
      end
    end

    settle();
    $display("%0d words over %0d patterns, with both sides idling in turn",
             words_sent, patterns_run);
    $display("checked %0d cells, %0d clean ends, %0d length mismatches, %0d bad channels",
             cells_seen, done_seen, mismatch_seen, badch_seen);
    if (fail_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
